### hdl/assert_macros.svh
// Assertion macros for the checker of the radix-64 text encoder.
// Include guard keeps the definitions single; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is held.
`define R64E_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define R64E_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/r64e_pkg.sv
// Package for the radix-64 text encoder: widths, group record, alphabet map.
// No dependencies.
`default_nettype none
package r64e_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SIX_W      = 6;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Alphabet offsets
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'd48;
    localparam logic [CHAR_W-1:0] UPPER_BASE = 7'd54;
    localparam logic [CHAR_W-1:0] LOWER_BASE = 7'd60;
    localparam logic [CHAR_W-1:0] CHAR_HASH  = 7'd35;

    localparam logic [SIX_W-1:0] LAST_DIGIT = 6'd9;
    localparam logic [SIX_W-1:0] LAST_UPPER = 6'd36;
    localparam logic [SIX_W-1:0] LAST_LOWER = 6'd62;

    // Fill level of the open group
    typedef enum logic [1:0] {
        POS_EMPTY = 2'd0,
        POS_ONE   = 2'd1,
        POS_TWO   = 2'd2,
        POS_SPARE = 2'd3
    } t_group_pos;

    // Character slot within a group
    typedef enum logic [1:0] {
        SLOT_B1  = 2'd0,
        SLOT_B2  = 2'd1,
        SLOT_B3  = 2'd2,
        SLOT_TOP = 2'd3
    } t_slot;

    typedef struct packed {
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic              last;
    } t_group;

    function automatic logic [CHAR_W-1:0] six_to_char(input logic [SIX_W-1:0] v);
        logic [CHAR_W-1:0] v7;
        v7 = {1'b0, v};
        if (v <= LAST_DIGIT)      six_to_char = v7 + DIGIT_BASE;
        else if (v <= LAST_UPPER) six_to_char = v7 + UPPER_BASE;
        else if (v <= LAST_LOWER) six_to_char = v7 + LOWER_BASE;
        else                      six_to_char = CHAR_HASH;
    endfunction

endpackage
`default_nettype wire

### hdl/r64e_stream_if.sv
// Valid/ready stream interfaces for the byte input and the character output.
// Depends on r64e_pkg for field widths.
`default_nettype none
interface r64e_byte_if;
    logic                         valid;
    logic                         ready;
    logic [r64e_pkg::BYTE_W-1:0]  data_byte;
    logic                         end_of_message;

    modport source(output valid, data_byte, end_of_message, input ready);
    modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface r64e_char_if;
    logic                         valid;
    logic                         ready;
    logic [r64e_pkg::CHAR_W-1:0]  text_char;
    logic                         last_char;

    modport source(output valid, text_char, last_char, input ready);
    modport sink(input valid, text_char, last_char, output ready);
endinterface
`default_nettype wire

### hdl/r64e_front.sv
// Front end: collects bytes into groups of three, closes short groups on end of message.
// Depends on r64e_pkg.
`default_nettype none
module r64e_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [r64e_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                         i_end_of_message,
    output logic                              o_push,
    output r64e_pkg::t_group                  o_group,
    input  wire logic                         i_space
);
    r64e_pkg::t_group_pos         r_pos, n_pos;
    logic [r64e_pkg::BYTE_W-1:0]  r_b1, n_b1;
    logic [r64e_pkg::BYTE_W-1:0]  r_b2, n_b2;
    logic                         w_accept;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;

    always_comb begin
        n_pos   = r_pos;
        n_b1    = r_b1;
        n_b2    = r_b2;
        o_push  = 1'b0;
        o_group = '{b1: i_data_byte, b2: '0, b3: '0, last: 1'b1};
        case (r_pos)
            r64e_pkg::POS_ONE: begin
                o_group = '{b1: r_b1, b2: i_data_byte, b3: '0, last: 1'b1};
                if (w_accept) begin
                    if (i_end_of_message) begin
                        o_push = 1'b1;
                        n_pos  = r64e_pkg::POS_EMPTY;
                        n_b1   = '0;
                    end else begin
                        n_b2  = i_data_byte;
                        n_pos = r64e_pkg::POS_TWO;
                    end
                end
            end
            r64e_pkg::POS_TWO: begin
                o_group = '{b1: r_b1, b2: r_b2, b3: i_data_byte, last: i_end_of_message};
                if (w_accept) begin
                    o_push = 1'b1;
                    n_pos  = r64e_pkg::POS_EMPTY;
                    n_b1   = '0;
                    n_b2   = '0;
                end
            end
            default: begin
                // empty group; the spare code is treated the same way
                if (w_accept) begin
                    if (i_end_of_message) begin
                        o_push = 1'b1;
                        n_pos  = r64e_pkg::POS_EMPTY;
                    end else begin
                        n_b1  = i_data_byte;
                        n_pos = r64e_pkg::POS_ONE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= r64e_pkg::POS_EMPTY;
            r_b1  <= '0;
            r_b2  <= '0;
        end else begin
            r_pos <= n_pos;
            r_b1  <= n_b1;
            r_b2  <= n_b2;
        end
    end
endmodule
`default_nettype wire

### hdl/r64e_queue.sv
// Short group queue between front and back ends.
// Depends on r64e_pkg for the group record.
`default_nettype none
module r64e_queue #(
    parameter int unsigned DEPTH = r64e_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire r64e_pkg::t_group i_group,
    output logic                  o_space,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output r64e_pkg::t_group      o_group
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    r64e_pkg::t_group   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_space = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_group = r_mem[r_rd];
    assign w_push  = i_push && o_space;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (w_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (w_push && !w_pop)      n_cnt = r_cnt + 1'b1;
        else if (w_pop && !w_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_group;
    end
endmodule
`default_nettype wire

### hdl/r64e_back.sv
// Back end: splits a group into four six-bit values, maps them to characters,
// and holds each one in the output register. Depends on r64e_pkg.
`default_nettype none
module r64e_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire r64e_pkg::t_group             i_q_group,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [r64e_pkg::CHAR_W-1:0]       o_text_char,
    output logic                              o_last_char
);
    r64e_pkg::t_group              r_grp, n_grp;
    logic                          r_busy, n_busy;
    r64e_pkg::t_slot               r_slot, n_slot;
    logic                          r_ovalid, n_ovalid;
    logic [r64e_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                          r_last, n_last;
    logic                          w_adv;
    logic [r64e_pkg::SIX_W-1:0]    w_six;

    assign o_valid     = r_ovalid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

    always_comb begin
        case (r_slot)
            r64e_pkg::SLOT_B1: w_six = r_grp.b1[r64e_pkg::SIX_W-1:0];
            r64e_pkg::SLOT_B2: w_six = r_grp.b2[r64e_pkg::SIX_W-1:0];
            r64e_pkg::SLOT_B3: w_six = r_grp.b3[r64e_pkg::SIX_W-1:0];
            default:           w_six = {r_grp.b1[7:6], r_grp.b2[7:6], r_grp.b3[7:6]};
        endcase
    end

    always_comb begin
        w_adv    = !r_ovalid || i_ready;
        n_grp    = r_grp;
        n_busy   = r_busy;
        n_slot   = r_slot;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;
        o_pop    = i_q_valid && (!r_busy || (w_adv && r_slot == r64e_pkg::SLOT_TOP));
        if (w_adv) begin
            n_ovalid = r_busy;
            if (r_busy) begin
                n_char = r64e_pkg::six_to_char(w_six);
                n_last = r_grp.last && (r_slot == r64e_pkg::SLOT_TOP);
                n_slot = r64e_pkg::t_slot'(r_slot + 2'd1);
                if (r_slot == r64e_pkg::SLOT_TOP) n_busy = 1'b0;
            end
        end
        // load the next group over the one just finished
        if (o_pop) begin
            n_grp  = i_q_group;
            n_busy = 1'b1;
            n_slot = r64e_pkg::SLOT_B1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_slot   <= r64e_pkg::SLOT_B1;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_slot   <= n_slot;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_char <= n_char;
        r_last <= n_last;
    end
endmodule
`default_nettype wire

### hdl/radix64_text_encoder.sv
// Path: a byte that closes a group is written to the group queue, then loaded into the back
// end's group register, and its first character is mapped into the output register for o_text.
// Throughput: one character per cycle out of the back end while o_text is ready and a group
// is queued, four per group; the character port, not the byte port, limits the input rate.
// Input is refused only while the group queue is full.
// Reset: synchronous, active low; clears the open group, the queue and the output.
`default_nettype none
module radix64_text_encoder #(
    parameter int unsigned QUEUE_DEPTH = r64e_pkg::QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    r64e_byte_if.sink     i_byte,
    r64e_char_if.source   o_text
);
    // Front end to queue
    logic               w_push;
    logic               w_space;
    r64e_pkg::t_group   w_push_group;

    // Queue to back end
    logic               w_q_valid;
    logic               w_pop;
    r64e_pkg::t_group   w_q_group;

    // Front: gather bytes, close a group on its third byte or on end of message,
    // padding the missing bytes with zero.
    r64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_byte.valid),
        .o_ready          (i_byte.ready),
        .i_data_byte      (i_byte.data_byte),
        .i_end_of_message (i_byte.end_of_message),
        .o_push           (w_push),
        .o_group          (w_push_group),
        .i_space          (w_space)
    );

    // Queue: decouple the byte side from the character side so either may stall.
    r64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_push_group),
        .o_space (w_space),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_group (w_q_group)
    );

    // Back: emit low six bits of each byte, then the packed top bits,
    // flagging the fourth character of the closing group.
    r64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_group   (w_q_group),
        .o_pop       (w_pop),
        .o_valid     (o_text.valid),
        .i_ready     (o_text.ready),
        .o_text_char (o_text.text_char),
        .o_last_char (o_text.last_char)
    );
endmodule
`default_nettype wire

### hdl/r64e_checker.sv
// Port-level checker for the radix-64 text encoder, bound to the top level.
// Depends on r64e_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module r64e_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [r64e_pkg::CHAR_W-1:0]  i_text_char,
    input wire logic                         i_last_char
);
    logic [1:0] r_out_cnt;
    logic       w_out_xfer;
    logic       w_in_alpha;

    assign w_out_xfer = i_out_valid && i_out_ready;
    assign w_in_alpha = (i_text_char >= 7'd48 && i_text_char <= 7'd57)
                     || (i_text_char >= 7'd64 && i_text_char <= 7'd90)
                     || (i_text_char >= 7'd97 && i_text_char <= 7'd122)
                     || (i_text_char == r64e_pkg::CHAR_HASH);

    // count transferred characters within the current group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_cnt <= '0;
        else if (w_out_xfer) r_out_cnt <= r_out_cnt + 2'd1;
    end

    `R64E_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `R64E_ASSERT(a_alphabet, i_clk, i_rst_n, i_out_valid |-> w_in_alpha, "character outside alphabet")
    `R64E_ASSERT(a_last_on_fourth, i_clk, i_rst_n, (i_out_valid && i_last_char) |-> (r_out_cnt == 2'd3), "last flag off fourth slot")
    `R64E_ASSERT(a_hold_stall, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_text_char) && $stable(i_last_char)), "stalled output changed")
endmodule

bind radix64_text_encoder r64e_checker u_r64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_text.valid),
    .i_out_ready (o_text.ready),
    .i_text_char (o_text.text_char),
    .i_last_char (o_text.last_char)
);
`default_nettype wire

### sim/radix64_text_encoder_tb.sv
// Self-checking testbench for radix64_text_encoder: bytes in, radix-64 characters out.
// Depends on r64e_pkg and the stream interfaces in r64e_stream_if.sv.
`default_nettype none
module radix64_text_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 100_000;
    // Settle time after the last character: group latency plus output stage, with margin.
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_OFF_CYCLES = 300;

    // Alphabet range edges for the six-bit code.
    localparam logic [r64e_pkg::SIX_W-1:0] SIX_FIRST_UPPER = 6'd10;
    localparam logic [r64e_pkg::SIX_W-1:0] SIX_FIRST_LOWER = 6'd37;
    localparam logic [r64e_pkg::SIX_W-1:0] SIX_HASH        = 6'd63;

    typedef struct packed {
        logic [r64e_pkg::CHAR_W-1:0] text_char;
        logic                        last_char;
    } t_char_result;

    logic i_clk;
    logic i_rst_n;

    r64e_byte_if byte_bus ();
    r64e_char_if text_bus ();

    radix64_text_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_text  (text_bus)
    );

    // Characters still owed by the block, oldest first.
    t_char_result pending_chars[$];
    int unsigned  mismatch_count;
    int unsigned  cycle_count;

    // Idle bursts on both sides while set; a hold-off request stalls the sink outright.
    bit          gaps_on;
    int unsigned hold_request;

    // Shadow of the open group.
    logic [r64e_pkg::BYTE_W-1:0] open_b1;
    logic [r64e_pkg::BYTE_W-1:0] open_b2;
    r64e_pkg::t_group_pos        open_pos;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d characters outstanding",
                     $time, pending_chars.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [r64e_pkg::CHAR_W-1:0] alphabet_char(
        input logic [r64e_pkg::SIX_W-1:0] six);
        logic [r64e_pkg::CHAR_W-1:0] wide;
        wide = r64e_pkg::CHAR_W'(six);
        if (six == SIX_HASH)        return r64e_pkg::CHAR_HASH;
        if (six >= SIX_FIRST_LOWER) return wide + r64e_pkg::LOWER_BASE;
        if (six >= SIX_FIRST_UPPER) return wide + r64e_pkg::UPPER_BASE;
        return wide + r64e_pkg::DIGIT_BASE;
    endfunction

    // Queue the four characters of a finished group and clear the shadow.
    function automatic void close_group(input logic [r64e_pkg::BYTE_W-1:0] b1,
                                        input logic [r64e_pkg::BYTE_W-1:0] b2,
                                        input logic [r64e_pkg::BYTE_W-1:0] b3,
                                        input logic                        ends_message);
        logic [r64e_pkg::SIX_W-1:0] top_bits;
        top_bits = {b1[7:6], b2[7:6], b3[7:6]};
        pending_chars.push_back('{alphabet_char(b1[5:0]), 1'b0});
        pending_chars.push_back('{alphabet_char(b2[5:0]), 1'b0});
        pending_chars.push_back('{alphabet_char(b3[5:0]), 1'b0});
        pending_chars.push_back('{alphabet_char(top_bits), ends_message});
        open_b1  = '0;
        open_b2  = '0;
        open_pos = r64e_pkg::POS_EMPTY;
    endfunction

    // Advance the shadow by one accepted byte.
    function automatic void encode_byte(input logic [r64e_pkg::BYTE_W-1:0] data,
                                        input logic                        eom);
        case (open_pos)
            r64e_pkg::POS_ONE: begin
                if (eom) begin
                    close_group(open_b1, data, '0, 1'b1);
                end else begin
                    open_b2  = data;
                    open_pos = r64e_pkg::POS_TWO;
                end
            end
            r64e_pkg::POS_TWO: begin
                close_group(open_b1, open_b2, data, eom);
            end
            default: begin
                // Empty group, or the unused spare position read as empty.
                if (eom) begin
                    close_group(data, '0, '0, 1'b1);
                end else begin
                    open_b1  = data;
                    open_pos = r64e_pkg::POS_ONE;
                end
            end
        endcase
    endfunction

    // Character sink: random stall bursts, plus a long hold-off on request.
    initial begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left      = 0;
        stall_left     = 0;
        text_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                text_bus.ready = 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                text_bus.ready = 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 6) == 0) begin
                stall_left     = $urandom_range(1, 15) - 1;
                text_bus.ready = 1'b0;
            end else begin
                text_bus.ready = 1'b1;
            end
        end
    end

    // Check every character transfer against the oldest one owed.
    always @(posedge i_clk) begin
        t_char_result want;
        if (i_rst_n && text_bus.valid && text_bus.ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual char=%0d last=%0b",
                         $time, text_bus.text_char, text_bus.last_char);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (text_bus.text_char !== want.text_char) begin
                    $display("%0t: text_char mismatch: expected %0d, actual %0d",
                             $time, want.text_char, text_bus.text_char);
                    mismatch_count++;
                end
                if (text_bus.last_char !== want.last_char) begin
                    $display("%0t: last_char mismatch: expected %0b, actual %0b",
                             $time, want.last_char, text_bus.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one byte from a falling edge, hold it until the transfer, then drop valid.
    task automatic send_byte(input logic [r64e_pkg::BYTE_W-1:0] data, input logic eom);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            byte_bus.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        byte_bus.valid          = 1'b1;
        byte_bus.data_byte      = data;
        byte_bus.end_of_message = eom;
        do @(posedge i_clk); while (!byte_bus.ready);
        encode_byte(data, eom);
        @(negedge i_clk);
        byte_bus.valid = 1'b0;
    endtask

    task automatic send_random_message(input int unsigned len);
        logic [r64e_pkg::BYTE_W-1:0] data;
        for (int unsigned k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0:       data = '0;
                1:       data = '1;
                default: data = r64e_pkg::BYTE_W'($urandom_range(0, 255));
            endcase
            send_byte(data, k == len - 1);
        end
    endtask

    // Mostly short messages, now and then a longer one.
    function automatic int unsigned pick_length();
        if ($urandom_range(0, 4) == 0) return $urandom_range(7, 20);
        return $urandom_range(1, 6);
    endfunction

    // Pause the source until every owed character has been transferred.
    task automatic wait_drained();
        byte_bus.valid = 1'b0;
        while (pending_chars.size() != 0) @(negedge i_clk);
    endtask

    task automatic apply_reset();
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    // Message closes on the first byte of a group: two zero pad bytes.
    task automatic test_single_byte_messages();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // Message closes on the second byte: one zero pad byte.
    task automatic test_two_byte_messages();
        send_byte(8'h3F, 1'b0);
        send_byte(8'hC0, 1'b1);
    endtask

    // Full groups: alphabet range edges 9/10, 36/37, 62/63, message closing on byte three.
    task automatic test_full_groups();
        send_byte(8'h09, 1'b0);
        send_byte(8'h4A, 1'b0);
        send_byte(8'hA4, 1'b0);
        send_byte(8'h25, 1'b0);
        send_byte(8'h3E, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Zero bytes inside a message are plain data.
    task automatic test_zero_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Stall the sink long enough that the group queue fills and input backs up.
    task automatic test_receiver_hold_off();
        gaps_on      = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        @(negedge i_clk);
        send_random_message(12);
        send_random_message(9);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_messages(input int unsigned byte_budget);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < byte_budget) begin
            len = pick_length();
            send_random_message(len);
            sent += len;
            if (gaps_on && $urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_streaming_tail(input int unsigned byte_budget);
        gaps_on = 1'b0;
        test_random_messages(byte_budget);
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        byte_bus.valid          = 1'b0;
        byte_bus.data_byte      = '0;
        byte_bus.end_of_message = 1'b0;
        mismatch_count          = 0;
        cycle_count             = 0;
        hold_request            = 0;
        gaps_on                 = 1'b1;
        open_b1                 = '0;
        open_b2                 = '0;
        open_pos                = r64e_pkg::POS_EMPTY;

        apply_reset();
        test_single_byte_messages();
        test_two_byte_messages();
        test_full_groups();
        test_zero_bytes();
        wait_drained();
        test_receiver_hold_off();
        test_random_messages(70);
        test_streaming_tail(20);

        // Let the last characters out, then give any stray transfer time to show.
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
